### design/orsb_pkg.sv
// Shared types and field layout for the overwrite-oldest ring sample buffer.
`default_nettype none

package orsb_pkg;

  // Operation codes carried in the input tuser field
  typedef enum logic [1:0] {
    FuncPush       = 2'd0,
    FuncPeekAge    = 2'd1,
    FuncPeekNewest = 2'd2,
    FuncClear      = 2'd3
  } func_e;

  // Field widths of the stream items
  localparam int unsigned FuncW   = 2;
  localparam int unsigned AgeW    = 8;
  localparam int unsigned SampleW = 64;
  localparam int unsigned CountW  = 8;

  // Input tdata layout: age_index, then sample_in; padded to whole bytes
  localparam int unsigned InAgeLsb    = 0;
  localparam int unsigned InSampleLsb = InAgeLsb + AgeW;
  localparam int unsigned InDataW     = ((InSampleLsb + SampleW + 7) / 8) * 8;

  // Output tdata layout: sample_out, then entry_count; padded to whole bytes
  localparam int unsigned OutSampleLsb = 0;
  localparam int unsigned OutCountLsb  = OutSampleLsb + SampleW;
  localparam int unsigned OutDataW     = ((OutCountLsb + CountW + 7) / 8) * 8;

  // One result item before the output skid stage
  typedef struct packed {
    logic               status;
    logic [SampleW-1:0] sample;
    logic [CountW-1:0]  count;
  } result_t;

endpackage : orsb_pkg

`default_nettype wire

### design/overwrite_ring_sample_buffer_top.sv
// Top level: overwrite-oldest ring buffer of sample records with stream ports.
//
//  Channel   Dir  Group            tuser                   tdata (low bit up)
//  --------  ---  ---------------  ----------------------  ------------------------------
//  request   in   s_axis_*         func[1:0]               age_index[7:0], sample_in[63:0]
//  response  out  m_axis_*         status[0]               sample_out[63:0], entry_count[7:0]
//
//  One item is accepted per cycle while s_axis tready is high; each gives one
//  result item. Acceptance updates the pointers and does the registered memory
//  read into the read stage, which hands the result to the output register or,
//  if the output is stalled, to a skid register. So s_axis tready depends only
//  on registered state and drops only while skid and read stage are both full.
//  Reset (rst_ni low) empties the ring at once; sample memory is not cleared.
`default_nettype none

module overwrite_ring_sample_buffer_top
  import orsb_pkg::*;
#(
  parameter int unsigned DEPTH        = 256,
  parameter int unsigned SAMPLE_WIDTH = 64
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,

  input  wire logic                s_axis_tvalid_i,
  output      logic                s_axis_tready_o,
  input  wire logic [FuncW-1:0]    s_axis_tuser_i,   // func[1:0]
  input  wire logic [InDataW-1:0]  s_axis_tdata_i,   // age_index[7:0], sample_in[71:8]

  output      logic                m_axis_tvalid_o,
  input  wire logic                m_axis_tready_i,
  output      logic                m_axis_tuser_o,   // status[0]
  output      logic [OutDataW-1:0] m_axis_tdata_o    // sample_out[63:0], entry_count[71:64]
);

  localparam int unsigned PtrW = (DEPTH > 2) ? $clog2(DEPTH) : 1;
  localparam int unsigned CmpW = (PtrW > AgeW) ? PtrW : AgeW;
  localparam int unsigned SumW = PtrW + 1;
  localparam logic [PtrW-1:0] LastSlot = PtrW'(DEPTH - 1);
  localparam logic [SumW-1:0] DepthSum = SumW'(DEPTH);

  // Input field split
  func_e                   func;
  logic [AgeW-1:0]         age_index;
  logic [SAMPLE_WIDTH-1:0] sample_in;

  assign func      = func_e'(s_axis_tuser_i);
  assign age_index = s_axis_tdata_i[InAgeLsb +: AgeW];
  assign sample_in = s_axis_tdata_i[InSampleLsb +: SAMPLE_WIDTH];

  // Ring state
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] old_ptr_q, old_ptr_d;
  logic [PtrW-1:0] count_q, count_d;

  // Sample memory
  logic [SAMPLE_WIDTH-1:0] sample_mem_q [DEPTH];
  logic [SAMPLE_WIDTH-1:0] rdata_q;

  // Read stage
  logic            s1_valid_q;
  logic            s1_status_q, s1_status_d;
  logic            s1_hit_q, s1_hit_d;
  logic [CountW-1:0] s1_count_q;

  // Output and skid stages
  logic    out_valid_q, skid_valid_q;
  result_t out_q, skid_q, s1_result;

  logic            accept;
  logic            wr_en, rd_en;
  logic [PtrW-1:0] rd_addr;
  logic [PtrW-1:0] wr_next, old_next, newest;
  logic [SumW-1:0] age_sum;
  logic [PtrW-1:0] age_slot;
  logic            age_ok;
  logic            s1_move, out_take;

  assign s_axis_tready_o = !s1_valid_q || !skid_valid_q;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  // Pointer arithmetic
  always_comb begin
    wr_next  = (wr_ptr_q == LastSlot) ? '0 : wr_ptr_q + 1'b1;
    old_next = (old_ptr_q == LastSlot) ? '0 : old_ptr_q + 1'b1;
    newest   = (wr_ptr_q == '0) ? LastSlot : wr_ptr_q - 1'b1;
    age_ok   = CmpW'(age_index) < CmpW'(count_q);
    age_sum  = SumW'(old_ptr_q) + SumW'(PtrW'(age_index));
    age_slot = (age_sum >= DepthSum) ? PtrW'(age_sum - DepthSum) : PtrW'(age_sum);
  end

  // Operation decode
  always_comb begin
    wr_ptr_d    = wr_ptr_q;
    old_ptr_d   = old_ptr_q;
    count_d     = count_q;
    wr_en       = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = age_slot;
    s1_status_d = 1'b0;
    s1_hit_d    = 1'b0;
    case (func)
      FuncPush: begin
        wr_en    = accept;
        wr_ptr_d = wr_next;
        if (wr_next == old_ptr_q) begin
          old_ptr_d = old_next;
        end else begin
          count_d = count_q + 1'b1;
        end
      end
      FuncPeekAge: begin
        rd_addr     = age_slot;
        rd_en       = accept && age_ok;
        s1_hit_d    = age_ok;
        s1_status_d = !age_ok;
      end
      FuncPeekNewest: begin
        rd_addr     = newest;
        rd_en       = accept && (count_q != '0);
        s1_hit_d    = (count_q != '0);
        s1_status_d = (count_q == '0);
      end
      FuncClear: begin
        wr_ptr_d  = '0;
        old_ptr_d = '0;
        count_d   = '0;
      end
      default: begin
        wr_ptr_d = wr_ptr_q;
      end
    endcase
  end

  // Ring pointers and read-stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q   <= '0;
      old_ptr_q  <= '0;
      count_q    <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        wr_ptr_q   <= wr_ptr_d;
        old_ptr_q  <= old_ptr_d;
        count_q    <= count_d;
        s1_valid_q <= 1'b1;
      end else if (s1_move) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  // Read-stage payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_status_q <= s1_status_d;
      s1_hit_q    <= s1_hit_d;
      s1_count_q  <= CountW'(count_d);
    end
  end

  // Memory write port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      sample_mem_q[wr_ptr_q] <= sample_in;
    end
  end

  // Memory read port, registered
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= sample_mem_q[rd_addr];
    end
  end

  // Result of the read stage; a failed peek or a non-read gives zero
  always_comb begin
    s1_result.status = s1_status_q;
    s1_result.sample = s1_hit_q ? SampleW'(rdata_q) : '0;
    s1_result.count  = s1_count_q;
  end

  assign s1_move  = s1_valid_q && !skid_valid_q;
  assign out_take = !out_valid_q || m_axis_tready_i;

  // Output register with skid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (out_take) begin
        if (skid_valid_q) begin
          out_valid_q  <= 1'b1;
          skid_valid_q <= 1'b0;
        end else begin
          out_valid_q <= s1_move;
        end
      end else if (s1_move) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_take) begin
      out_q <= skid_valid_q ? skid_q : s1_result;
    end
    if (!out_take && s1_move) begin
      skid_q <= s1_result;
    end
  end

  // Output ports
  always_comb begin
    m_axis_tdata_o                            = '0;
    m_axis_tdata_o[OutSampleLsb +: SampleW]   = out_q.sample;
    m_axis_tdata_o[OutCountLsb +: CountW]     = out_q.count;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_q.status;

endmodule : overwrite_ring_sample_buffer_top

`default_nettype wire

### dv/orsb_ring_checker.sv
// Checker for the ring sample buffer: mirrors the ring, queues expected results, compares.
`default_nettype none

module orsb_ring_checker
  import orsb_pkg::*;
#(
  parameter int unsigned DEPTH        = 256,
  parameter int unsigned SAMPLE_WIDTH = 64
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,

  input  wire logic                req_valid_i,
  input  wire logic                req_ready_i,
  input  wire logic [FuncW-1:0]    req_user_i,   // func[1:0]
  input  wire logic [InDataW-1:0]  req_data_i,   // age_index[7:0], sample_in[71:8]

  input  wire logic                rsp_valid_i,
  input  wire logic                rsp_ready_i,
  input  wire logic                rsp_user_i,   // status[0]
  input  wire logic [OutDataW-1:0] rsp_data_i,   // sample_out[63:0], entry_count[71:64]

  output int                       mismatch_cnt_o,
  output int                       pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [SampleW-1:0] SampleMask =
      (SAMPLE_WIDTH >= 64) ? {SampleW{1'b1}} : ((64'd1 << SAMPLE_WIDTH) - 64'd1);

  // Shadow of the ring: store, pointers and fill level
  logic [SampleW-1:0] ring_mem [DEPTH];
  int unsigned        wr_ptr;
  int unsigned        old_ptr;
  int unsigned        held;

  // Results still owed by the block, oldest first
  result_t            owed_results [$];

  function automatic int unsigned next_slot(int unsigned p);
    return (p + 1 >= DEPTH) ? 0 : p + 1;
  endfunction

  // Apply one request to the shadow ring and return the result it should give
  function automatic result_t apply_request(func_e op, logic [AgeW-1:0] age,
                                            logic [SampleW-1:0] smp);
    result_t     res;
    int unsigned want;
    int unsigned slot;
    res  = '0;
    want = age;
    case (op)
      FuncPush: begin
        // full ring drops its oldest entry first
        if (next_slot(wr_ptr) == old_ptr) old_ptr = next_slot(old_ptr);
        else held++;
        ring_mem[wr_ptr] = smp & SampleMask;
        wr_ptr = next_slot(wr_ptr);
      end
      FuncPeekAge, FuncPeekNewest: begin
        if (op == FuncPeekNewest) want = held - 1;
        if (held == 0 || want >= held) begin
          res.status = 1'b1;
        end else begin
          slot = old_ptr + want;
          if (slot >= DEPTH) slot -= DEPTH;
          res.sample = ring_mem[slot] & SampleMask;
        end
      end
      default: begin
        wr_ptr  = 0;
        old_ptr = 0;
        held    = 0;
      end
    endcase
    res.count = CountW'(held);
    return res;
  endfunction

  // Compare each result item against the oldest one owed, then predict new requests
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    result_t seen;
    result_t want;
    if (!rst_ni) begin
      wr_ptr         = 0;
      old_ptr        = 0;
      held           = 0;
      mismatch_cnt_o = 0;
      owed_results.delete();
    end else begin
      if (rsp_valid_i && rsp_ready_i) begin
        seen.status = rsp_user_i;
        seen.sample = rsp_data_i[OutSampleLsb +: SampleW];
        seen.count  = rsp_data_i[OutCountLsb +: CountW];
        if (owed_results.size() == 0) begin
          $display("%0t: unexpected result item: status=%0b sample=%h count=%0d",
                   $time, seen.status, seen.sample, seen.count);
          mismatch_cnt_o++;
        end else begin
          want = owed_results.pop_front();
          if (seen !== want) begin
            $display("%0t: result mismatch: expected status=%0b sample=%h count=%0d",
                     $time, want.status, want.sample, want.count);
            $display("%0t:                  actual   status=%0b sample=%h count=%0d",
                     $time, seen.status, seen.sample, seen.count);
            mismatch_cnt_o++;
          end
        end
      end
      if (req_valid_i && req_ready_i) begin
        owed_results.push_back(apply_request(func_e'(req_user_i),
                                             req_data_i[InAgeLsb +: AgeW],
                                             req_data_i[InSampleLsb +: SampleW]));
      end
    end
    pending_o = owed_results.size();
  end

endmodule : orsb_ring_checker

`default_nettype wire

### dv/overwrite_ring_sample_buffer_top_tb.sv
// Testbench top for the ring sample buffer: clock, reset, request and response traffic, verdict.
`default_nettype none

module overwrite_ring_sample_buffer_top_tb
  import orsb_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Depth       = 256;
  localparam int unsigned SampleWidth = 64;
  localparam int unsigned ResetCycles = 12;
  localparam int unsigned RandomItems = 1250;
  localparam int unsigned HoldItems   = 40;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned DrainItems  = 150;
  localparam int unsigned SettleCycles = 20;

  typedef enum int {
    PhDirected,
    PhRandom,
    PhHold,
    PhDrain
  } run_phase_e;

  logic                clk      = 1'b0;
  logic                rst_n    = 1'b0;
  logic                s_tvalid = 1'b0;
  logic [FuncW-1:0]    s_tuser  = '0;   // func[1:0]
  logic [InDataW-1:0]  s_tdata  = '0;   // age_index[7:0], sample_in[71:8]
  logic                s_tready;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic                m_tuser;         // status[0]
  logic [OutDataW-1:0] m_tdata;         // sample_out[63:0], entry_count[71:64]

  int                  mismatches;
  int                  pending_items;
  run_phase_e          run_phase   = PhDirected;
  bit                  hold_active = 1'b0;
  bit                  hold_done   = 1'b0;
  int unsigned         fill_level  = 0;   // rough fill level, only to steer peek ages

  overwrite_ring_sample_buffer_top #(
    .DEPTH        (Depth),
    .SAMPLE_WIDTH (SampleWidth)
  ) uut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tuser_i  (s_tuser),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tdata_o  (m_tdata)
  );

  orsb_ring_checker #(
    .DEPTH        (Depth),
    .SAMPLE_WIDTH (SampleWidth)
  ) ring_check (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .req_valid_i    (s_tvalid),
    .req_ready_i    (s_tready),
    .req_user_i     (s_tuser),
    .req_data_i     (s_tdata),
    .rsp_valid_i    (m_tvalid),
    .rsp_ready_i    (m_tready),
    .rsp_user_i     (m_tuser),
    .rsp_data_i     (m_tdata),
    .mismatch_cnt_o (mismatches),
    .pending_o      (pending_items)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Offer one request item and hold it until accepted
  task automatic send_item(input func_e op, input logic [AgeW-1:0] age,
                           input logic [SampleW-1:0] smp);
    logic [InDataW-1:0] word;
    word = '0;
    word[InAgeLsb +: AgeW]       = age;
    word[InSampleLsb +: SampleW] = smp;
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= word;
    do @(posedge clk); while (!s_tready);
    case (op)
      FuncPush:  if (fill_level < Depth - 1) fill_level++;
      FuncClear: fill_level = 0;
      default:   ;
    endcase
  endtask

  task automatic idle_input(input int unsigned cycles);
    s_tvalid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Random request; peek ages mostly land inside the held range or on its edge
  task automatic send_random(input int unsigned push_pct);
    func_e           op;
    logic [AgeW-1:0] age;
    int unsigned     pick;
    pick = $urandom_range(0, 99);
    if (pick < push_pct) op = FuncPush;
    else if ($urandom_range(0, 199) == 0) op = FuncClear;
    else if ($urandom_range(0, 2) == 0) op = FuncPeekNewest;
    else op = FuncPeekAge;
    case ($urandom_range(0, 3))
      0:       age = AgeW'($urandom);
      1:       age = AgeW'(fill_level);
      default: age = (fill_level == 0) ? '0 : AgeW'($urandom_range(0, fill_level - 1));
    endcase
    send_item(op, age, {$urandom, $urandom});
  endtask

  // Response side: random stalls, one long hold-off, none while draining
  initial begin
    @(posedge clk);
    forever begin
      if (run_phase == PhHold && !hold_done) begin
        m_tready    <= 1'b0;
        hold_active = 1'b1;
        repeat (HoldCycles) @(posedge clk);
        hold_done   = 1'b1;
      end else if (run_phase != PhDrain && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        repeat ((run_phase == PhDrain) ? 1 : $urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  // Request side and verdict
  initial begin
    int unsigned sent;
    int unsigned seg_len;
    int unsigned push_pct;
    bit          first_seg;
    repeat (ResetCycles) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty ring, field extremes, age boundary, clear
    send_item(FuncPeekAge,    8'h00, {SampleW{1'b1}});
    send_item(FuncPeekNewest, 8'hFF, {SampleW{1'b1}});
    send_item(FuncClear,      8'hFF, {SampleW{1'b1}});
    send_item(FuncPush,       8'hFF, {SampleW{1'b1}});
    send_item(FuncPush,       8'h00, {SampleW{1'b0}});
    send_item(FuncPush,       8'h00, 64'h8000_0000_0000_0001);
    send_item(FuncPush,       8'h80, 64'h7FFF_FFFF_FFFF_FFFE);
    send_item(FuncPeekAge,    8'h00, {SampleW{1'b1}});
    send_item(FuncPeekAge,    8'h01, 64'h0);
    send_item(FuncPeekAge,    8'h02, 64'h0);
    send_item(FuncPeekAge,    8'h03, 64'h0);
    send_item(FuncPeekAge,    8'h04, 64'h0);
    send_item(FuncPeekAge,    8'hFF, 64'h0);
    send_item(FuncPeekNewest, 8'h00, 64'h0);
    idle_input(3);
    send_item(FuncClear,      8'h00, 64'h0);
    send_item(FuncPeekNewest, 8'h00, 64'h0);
    send_item(FuncPeekAge,    8'h00, 64'h0);
    send_item(FuncPush,       8'h55, 64'hA5A5_5A5A_C3C3_3C3C);
    send_item(FuncPeekNewest, 8'hAA, 64'h0);
    send_item(FuncPeekAge,    8'h00, 64'h0);
    send_item(FuncPeekAge,    8'h01, 64'h0);

    // random segments; the first fills the ring well past wrap
    run_phase = PhRandom;
    sent      = 0;
    first_seg = 1'b1;
    while (sent < RandomItems) begin
      seg_len  = first_seg ? 340 : $urandom_range(40, 250);
      push_pct = first_seg ? 85 : $urandom_range(20, 80);
      repeat (seg_len) begin
        send_random(push_pct);
        sent++;
        if ($urandom_range(0, 5) == 0) idle_input($urandom_range(1, 12));
      end
      if (first_seg) begin
        // back-to-back items against a stalled response side
        run_phase = PhHold;
        s_tvalid <= 1'b0;
        wait (hold_active);
        repeat (HoldItems) send_random(70);
        run_phase = PhRandom;
        first_seg = 1'b0;
      end
      if ($urandom_range(0, 2) == 0) send_item(FuncClear, AgeW'($urandom), {$urandom, $urandom});
    end

    // last stretch at full rate
    run_phase = PhDrain;
    repeat (DrainItems) send_random(50);
    idle_input(1);

    while (pending_items != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
    if (mismatches == 0 && pending_items == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2ms;
    $display("FAIL");
    $finish;
  end

endmodule : overwrite_ring_sample_buffer_top_tb

`default_nettype wire

### overwrite_ring_sample_buffer_top.f
design/orsb_pkg.sv
design/overwrite_ring_sample_buffer_top.sv
dv/orsb_ring_checker.sv
dv/overwrite_ring_sample_buffer_top_tb.sv
